[rtl/aesp_pkg.sv]
// ---------------------------------------------------------------------------
// aesp_pkg
// Shared constants, codes and control types of the escape sequence parser.
// ---------------------------------------------------------------------------
package aesp_pkg;

  localparam int MAX_PARAMS   = 5;
  localparam int MAX_DIGITS   = 4;
  localparam int MAX_SEQUENCE = 14;
  localparam int COORD_BITS   = 10;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;

  localparam int ACC_W   = 14;
  localparam int ACC_MAX = 16383;

  localparam int PIDX_W = $clog2(MAX_PARAMS + 1);
  localparam int DCNT_W = $clog2(MAX_DIGITS + 1);
  localparam int SLEN_W = $clog2(MAX_SEQUENCE + 1);
  // wide enough for a coordinate plus a parameter without overflow
  localparam int EXT_W  = ((COORD_BITS > ACC_W) ? COORD_BITS : ACC_W) + 1;

  localparam int BYTE_W  = 8;
  localparam int COLOR_W = 3;
  localparam int ATTR_W  = 4;
  localparam int LW_W    = 11;
  localparam int OUT_COORD_W = 10;
  localparam int CFG_IDX_W   = 2;

  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7A;

  // final letters
  localparam logic [BYTE_W-1:0] CH_SGR = 8'h6D;  // m
  localparam logic [BYTE_W-1:0] CH_CUP = 8'h48;  // H
  localparam logic [BYTE_W-1:0] CH_HVP = 8'h66;  // f
  localparam logic [BYTE_W-1:0] CH_CUU = 8'h41;  // A
  localparam logic [BYTE_W-1:0] CH_CUD = 8'h42;  // B
  localparam logic [BYTE_W-1:0] CH_CUF = 8'h43;  // C
  localparam logic [BYTE_W-1:0] CH_CUB = 8'h44;  // D
  localparam logic [BYTE_W-1:0] CH_SCP = 8'h73;  // s
  localparam logic [BYTE_W-1:0] CH_RCP = 8'h75;  // u
  localparam logic [BYTE_W-1:0] CH_ED  = 8'h4A;  // J
  localparam logic [BYTE_W-1:0] CH_EL  = 8'h4B;  // K

  // SGR codes
  localparam logic [ACC_W-1:0] SGR_RESET     = 14'd0;
  localparam logic [ACC_W-1:0] SGR_BOLD      = 14'd1;
  localparam logic [ACC_W-1:0] SGR_UNDERLINE = 14'd4;
  localparam logic [ACC_W-1:0] SGR_BLINK     = 14'd5;
  localparam logic [ACC_W-1:0] SGR_REVERSE   = 14'd7;
  localparam logic [ACC_W-1:0] SGR_FG_LO     = 14'd30;
  localparam logic [ACC_W-1:0] SGR_FG_HI     = 14'd37;
  localparam logic [ACC_W-1:0] SGR_BG_LO     = 14'd40;
  localparam logic [ACC_W-1:0] SGR_BG_HI     = 14'd47;
  localparam logic [ACC_W-1:0] ED_ALL        = 14'd2;

  localparam logic [COLOR_W-1:0] RST_FG   = 3'd7;
  localparam logic [COLOR_W-1:0] RST_BG   = 3'd0;
  localparam logic [ATTR_W-1:0]  RST_ATTR = 4'd0;
  localparam logic [LW_W-1:0]    RST_LW   = 11'd80;

  typedef enum logic {
    ST_TEXT,
    ST_SEQ
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LF,
    OP_BEGIN,
    OP_CHAR,
    OP_DIGIT,
    OP_CLOSE,
    OP_FINISH
  } op_t;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_CLEAR,
    KIND_ERASE
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_FG,
    REG_START_BG,
    REG_START_ATTR,
    REG_LINE_WIDTH
  } cfg_reg_t;

  typedef struct packed {
    op_t  op;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_lf;
    logic is_esc;
    logic is_digit;
    logic is_letter;
    logic seq_full;
    logic fin_result;
  } dp_status_t;

endpackage

[rtl/aesp_ctrl.sv]
// ---------------------------------------------------------------------------
// aesp_ctrl
// Parser state machine: text or escape sequence, input and result handshake.
// ---------------------------------------------------------------------------
module aesp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  aesp_pkg::dp_status_t st,
  output aesp_pkg::dp_cmd_t    cmd
);

  aesp_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      if (st.is_lf) begin
        state_nxt = aesp_pkg::ST_TEXT;
      end else begin
        unique case (state_r)
          aesp_pkg::ST_TEXT: begin
            if (st.is_esc) state_nxt = aesp_pkg::ST_SEQ;
          end
          aesp_pkg::ST_SEQ: begin
            if (st.seq_full || st.is_letter) state_nxt = aesp_pkg::ST_TEXT;
          end
          default: state_nxt = aesp_pkg::ST_TEXT;
        endcase
      end
    end
  end

  always_comb begin
    cmd.op = aesp_pkg::OP_NONE;
    if (accept) begin
      if (st.is_lf) begin
        cmd.op = aesp_pkg::OP_LF;
      end else begin
        unique case (state_r)
          aesp_pkg::ST_TEXT: begin
            cmd.op = st.is_esc ? aesp_pkg::OP_BEGIN : aesp_pkg::OP_CHAR;
          end
          aesp_pkg::ST_SEQ: begin
            // overlong sequence: byte dropped
            if (st.seq_full)       cmd.op = aesp_pkg::OP_NONE;
            else if (st.is_digit)  cmd.op = aesp_pkg::OP_DIGIT;
            else if (st.is_letter) cmd.op = aesp_pkg::OP_FINISH;
            else                   cmd.op = aesp_pkg::OP_CLOSE;
          end
          default: cmd.op = aesp_pkg::OP_NONE;
        endcase
      end
    end
    cmd.load_out = (cmd.op == aesp_pkg::OP_CHAR) ||
                   ((cmd.op == aesp_pkg::OP_FINISH) && st.fin_result);
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aesp_pkg::ST_TEXT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/aesp_dp.sv]
// ---------------------------------------------------------------------------
// aesp_dp
// Datapath: cursor, colors, parameter store, sequence actions, result register.
// ---------------------------------------------------------------------------
module aesp_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [aesp_pkg::BYTE_W-1:0]           in_byte,
  input  aesp_pkg::dp_cmd_t                     cmd,
  output aesp_pkg::dp_status_t                  st,
  input  logic                                  cfg_we,
  input  logic [aesp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aesp_pkg::LW_W-1:0]             cfg_data,
  output logic [1:0]                            out_kind,
  output logic [aesp_pkg::OUT_COORD_W-1:0]      out_row,
  output logic [aesp_pkg::OUT_COORD_W-1:0]      out_column,
  output logic [aesp_pkg::BYTE_W-1:0]           out_glyph,
  output logic [aesp_pkg::COLOR_W-1:0]          out_foreground,
  output logic [aesp_pkg::COLOR_W-1:0]          out_background,
  output logic                                  out_bold,
  output logic                                  out_underline,
  output logic                                  out_blink,
  output logic                                  out_reverse
);

  localparam int CB  = aesp_pkg::COORD_BITS;
  localparam int XW  = aesp_pkg::EXT_W;
  localparam int AW  = aesp_pkg::ACC_W;
  localparam int NP  = aesp_pkg::MAX_PARAMS;
  localparam int PW  = aesp_pkg::PIDX_W;
  localparam int CW  = aesp_pkg::COLOR_W;
  localparam int TW  = aesp_pkg::ATTR_W;

  typedef logic [CB-1:0] coord_t;
  typedef logic [AW-1:0] acc_t;

  function automatic coord_t sat_up(input logic [XW-1:0] v);
    if (v > XW'(aesp_pkg::COORD_MAX)) sat_up = CB'(aesp_pkg::COORD_MAX);
    else                              sat_up = v[CB-1:0];
  endfunction

  function automatic coord_t sat_down(input coord_t c, input acc_t d);
    if (XW'(d) > XW'(c)) sat_down = '0;
    else                 sat_down = c - CB'(d);
  endfunction

  // configuration
  logic [CW-1:0] sfg_r, sfg_nxt, sbg_r, sbg_nxt;
  logic [TW-1:0] sattr_r, sattr_nxt;
  logic [aesp_pkg::LW_W-1:0] lw_r, lw_nxt;

  // screen state
  coord_t row_r, row_nxt, col_r, col_nxt, srow_r, srow_nxt, scol_r, scol_nxt;
  logic [CW-1:0] fg_r, fg_nxt, bg_r, bg_nxt;
  logic [TW-1:0] attr_r, attr_nxt;

  // sequence state
  logic [aesp_pkg::SLEN_W-1:0] slen_r, slen_nxt;
  acc_t                        acc_r, acc_nxt;
  logic [aesp_pkg::DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [PW-1:0]               pidx_r, pidx_nxt;
  logic [NP-1:0]               pvalid_r, pvalid_nxt;
  acc_t                        pval [NP];

  // result register
  aesp_pkg::kind_t kind_r;
  coord_t          orow_r, ocol_r;
  logic [aesp_pkg::BYTE_W-1:0] glyph_r;
  logic [CW-1:0]   ofg_r, obg_r;
  logic [TW-1:0]   oattr_r;

  // number closing and the parameter view it leaves
  logic          close_ok, store_en;
  logic [NP-1:0] hit, ev;
  acc_t          vv [NP];
  acc_t          p0;

  logic [AW+3:0] acc_ext, acc_sum;
  acc_t          acc_sat;

  // finish results
  coord_t          fin_row, fin_col, fin_srow, fin_scol;
  logic [CW-1:0]   fin_fg, fin_bg;
  logic [TW-1:0]   fin_attr;
  logic            fin_result;
  aesp_pkg::kind_t fin_kind;

  logic is_close;

  assign st.is_lf     = (in_byte == aesp_pkg::CH_LF);
  assign st.is_esc    = (in_byte == aesp_pkg::CH_ESC);
  assign st.is_digit  = (in_byte >= aesp_pkg::CH_ZERO) && (in_byte <= aesp_pkg::CH_NINE);
  assign st.is_letter = ((in_byte >= aesp_pkg::CH_UP_A) && (in_byte <= aesp_pkg::CH_UP_Z)) ||
                        ((in_byte >= aesp_pkg::CH_LO_A) && (in_byte <= aesp_pkg::CH_LO_Z));
  assign st.seq_full  = (slen_r >= aesp_pkg::SLEN_W'(aesp_pkg::MAX_SEQUENCE));
  assign st.fin_result = fin_result;

  assign close_ok = (dcnt_r != '0) && (pidx_r < PW'(NP));
  assign is_close = (cmd.op == aesp_pkg::OP_CLOSE) || (cmd.op == aesp_pkg::OP_FINISH);
  assign store_en = is_close && close_ok;

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      hit[i] = close_ok && (pidx_r == PW'(i));
      ev[i]  = pvalid_r[i] || hit[i];
      vv[i]  = hit[i] ? acc_r : pval[i];
    end
    p0 = ev[0] ? vv[0] : '0;
  end

  // acc * 10 + digit, saturating
  always_comb begin
    acc_ext = (AW+4)'(acc_r);
    acc_sum = (acc_ext << 3) + (acc_ext << 1) + (AW+4)'(in_byte - aesp_pkg::CH_ZERO);
    acc_sat = (acc_sum > (AW+4)'(aesp_pkg::ACC_MAX)) ? AW'(aesp_pkg::ACC_MAX)
                                                     : acc_sum[AW-1:0];
  end

  // action of the final letter
  always_comb begin
    fin_row    = row_r;
    fin_col    = col_r;
    fin_srow   = srow_r;
    fin_scol   = scol_r;
    fin_fg     = fg_r;
    fin_bg     = bg_r;
    fin_attr   = attr_r;
    fin_result = 1'b0;
    fin_kind   = aesp_pkg::KIND_CHAR;
    case (in_byte) inside
      aesp_pkg::CH_SGR: begin
        // applied in parameter order, so a later reset wins
        for (int i = 0; i < NP; i++) begin
          if (ev[i]) begin
            if (vv[i] == aesp_pkg::SGR_RESET)          fin_attr = '0;
            else if (vv[i] == aesp_pkg::SGR_BOLD)      fin_attr = fin_attr | TW'(1);
            else if (vv[i] == aesp_pkg::SGR_UNDERLINE) fin_attr = fin_attr | TW'(2);
            else if (vv[i] == aesp_pkg::SGR_BLINK)     fin_attr = fin_attr | TW'(4);
            else if (vv[i] == aesp_pkg::SGR_REVERSE)   fin_attr = fin_attr | TW'(8);
            else if ((vv[i] >= aesp_pkg::SGR_FG_LO) && (vv[i] <= aesp_pkg::SGR_FG_HI))
              fin_fg = CW'(vv[i] - aesp_pkg::SGR_FG_LO);
            else if ((vv[i] >= aesp_pkg::SGR_BG_LO) && (vv[i] <= aesp_pkg::SGR_BG_HI))
              fin_bg = CW'(vv[i] - aesp_pkg::SGR_BG_LO);
          end
        end
      end
      aesp_pkg::CH_CUP, aesp_pkg::CH_HVP: begin
        if (ev[0]) fin_row = sat_up(XW'(vv[0]));
        if ((NP > 1) && ev[1 % NP]) fin_col = sat_up(XW'(vv[1 % NP]));
      end
      aesp_pkg::CH_CUU: begin
        if (ev[0]) fin_row = sat_down(row_r, p0);
      end
      aesp_pkg::CH_CUD: begin
        if (ev[0]) fin_row = sat_up(XW'(row_r) + XW'(p0));
      end
      aesp_pkg::CH_CUF: begin
        if (ev[0]) fin_col = sat_up(XW'(col_r) + XW'(p0));
      end
      aesp_pkg::CH_CUB: begin
        if (ev[0]) fin_col = sat_down(col_r, p0);
      end
      aesp_pkg::CH_SCP: begin
        fin_srow = row_r;
        fin_scol = col_r;
      end
      aesp_pkg::CH_RCP: begin
        fin_row = srow_r;
        fin_col = scol_r;
      end
      aesp_pkg::CH_ED: begin
        if (ev[0] && (vv[0] == aesp_pkg::ED_ALL)) begin
          fin_row    = '0;
          fin_col    = '0;
          fin_result = 1'b1;
          fin_kind   = aesp_pkg::KIND_CLEAR;
        end
      end
      aesp_pkg::CH_EL: begin
        if (32'(col_r) < 32'(lw_r)) begin
          fin_result = 1'b1;
          fin_kind   = aesp_pkg::KIND_ERASE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    srow_nxt   = srow_r;
    scol_nxt   = scol_r;
    fg_nxt     = fg_r;
    bg_nxt     = bg_r;
    attr_nxt   = attr_r;
    slen_nxt   = slen_r;
    acc_nxt    = acc_r;
    dcnt_nxt   = dcnt_r;
    pidx_nxt   = pidx_r;
    pvalid_nxt = pvalid_r;
    sfg_nxt    = sfg_r;
    sbg_nxt    = sbg_r;
    sattr_nxt  = sattr_r;
    lw_nxt     = lw_r;

    case (cmd.op)
      aesp_pkg::OP_LF: begin
        row_nxt = sat_up(XW'(row_r) + XW'(1));
        col_nxt = '0;
      end
      aesp_pkg::OP_BEGIN: begin
        slen_nxt   = '0;
        acc_nxt    = '0;
        dcnt_nxt   = '0;
        pidx_nxt   = '0;
        pvalid_nxt = '0;
      end
      aesp_pkg::OP_CHAR: begin
        col_nxt = sat_up(XW'(col_r) + XW'(1));
      end
      aesp_pkg::OP_DIGIT: begin
        slen_nxt = slen_r + 1'b1;
        if (dcnt_r < aesp_pkg::DCNT_W'(aesp_pkg::MAX_DIGITS)) begin
          acc_nxt  = acc_sat;
          dcnt_nxt = dcnt_r + 1'b1;
        end
      end
      aesp_pkg::OP_CLOSE, aesp_pkg::OP_FINISH: begin
        slen_nxt = slen_r + 1'b1;
        acc_nxt  = '0;
        dcnt_nxt = '0;
        if (store_en) begin
          pidx_nxt   = pidx_r + 1'b1;
          pvalid_nxt = pvalid_r | hit;
        end
        if (cmd.op == aesp_pkg::OP_FINISH) begin
          row_nxt  = fin_row;
          col_nxt  = fin_col;
          srow_nxt = fin_srow;
          scol_nxt = fin_scol;
          fg_nxt   = fin_fg;
          bg_nxt   = fin_bg;
          attr_nxt = fin_attr;
        end
      end
      default: ;
    endcase

    // start values also restart the current ones
    if (cfg_we) begin
      unique case (aesp_pkg::cfg_reg_t'(cfg_index))
        aesp_pkg::REG_START_FG: begin
          sfg_nxt = cfg_data[CW-1:0];
          fg_nxt  = cfg_data[CW-1:0];
        end
        aesp_pkg::REG_START_BG: begin
          sbg_nxt = cfg_data[CW-1:0];
          bg_nxt  = cfg_data[CW-1:0];
        end
        aesp_pkg::REG_START_ATTR: begin
          sattr_nxt = cfg_data[TW-1:0];
          attr_nxt  = cfg_data[TW-1:0];
        end
        aesp_pkg::REG_LINE_WIDTH: begin
          lw_nxt = cfg_data;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sfg_r    <= aesp_pkg::RST_FG;
      sbg_r    <= aesp_pkg::RST_BG;
      sattr_r  <= aesp_pkg::RST_ATTR;
      lw_r     <= aesp_pkg::RST_LW;
      row_r    <= '0;
      col_r    <= '0;
      srow_r   <= '0;
      scol_r   <= '0;
      fg_r     <= aesp_pkg::RST_FG;
      bg_r     <= aesp_pkg::RST_BG;
      attr_r   <= aesp_pkg::RST_ATTR;
      slen_r   <= '0;
      acc_r    <= '0;
      dcnt_r   <= '0;
      pidx_r   <= '0;
      pvalid_r <= '0;
    end else begin
      sfg_r    <= sfg_nxt;
      sbg_r    <= sbg_nxt;
      sattr_r  <= sattr_nxt;
      lw_r     <= lw_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      srow_r   <= srow_nxt;
      scol_r   <= scol_nxt;
      fg_r     <= fg_nxt;
      bg_r     <= bg_nxt;
      attr_r   <= attr_nxt;
      slen_r   <= slen_nxt;
      acc_r    <= acc_nxt;
      dcnt_r   <= dcnt_nxt;
      pidx_r   <= pidx_nxt;
      pvalid_r <= pvalid_nxt;
    end
  end

  // parameter store, no reset: read only where its valid bit is set
  always_ff @(posedge clk) begin
    for (int i = 0; i < NP; i++) begin
      if (store_en && hit[i]) pval[i] <= acc_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cmd.op == aesp_pkg::OP_CHAR) begin
        kind_r  <= aesp_pkg::KIND_CHAR;
        orow_r  <= row_r;
        ocol_r  <= col_r;
        glyph_r <= in_byte;
        ofg_r   <= fg_r;
        obg_r   <= bg_r;
        oattr_r <= attr_r;
      end else if (fin_kind == aesp_pkg::KIND_CLEAR) begin
        kind_r  <= aesp_pkg::KIND_CLEAR;
        orow_r  <= '0;
        ocol_r  <= '0;
        glyph_r <= aesp_pkg::CH_SPACE;
        ofg_r   <= fg_r;
        obg_r   <= bg_r;
        oattr_r <= attr_r;
      end else begin
        kind_r  <= aesp_pkg::KIND_ERASE;
        orow_r  <= row_r;
        ocol_r  <= col_r;
        glyph_r <= aesp_pkg::CH_SPACE;
        ofg_r   <= sfg_r;
        obg_r   <= sbg_r;
        oattr_r <= sattr_r;
      end
    end
  end

  assign out_kind       = kind_r;
  assign out_row        = aesp_pkg::OUT_COORD_W'(orow_r);
  assign out_column     = aesp_pkg::OUT_COORD_W'(ocol_r);
  assign out_glyph      = glyph_r;
  assign out_foreground = ofg_r;
  assign out_background = obg_r;
  assign out_bold       = oattr_r[0];
  assign out_underline  = oattr_r[1];
  assign out_blink      = oattr_r[2];
  assign out_reverse    = oattr_r[3];

endmodule

[rtl/ansi_escape_screen_parser.sv]
// ---------------------------------------------------------------------------
// ansi_escape_screen_parser
// Text byte stream to screen writes, with CSI cursor, color and erase codes.
// ---------------------------------------------------------------------------
// channel  direction  handshake              payload
// in_      input      in_valid / in_ready    in_input_byte
// out_     output     out_valid / out_ready  kind, row, column, glyph, colors, attrs
// cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle: each byte is decoded and acted on in the cycle it is
// accepted, and any result lands in the output register at that edge.
// in_ready drops only while a result sits in the output register and
// out_ready is low. cfg_ready is always high.
// Synchronous reset restores the start colors, attributes and line width.
// ---------------------------------------------------------------------------
module ansi_escape_screen_parser (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [aesp_pkg::BYTE_W-1:0]           in_input_byte,

  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            out_kind,
  output logic [aesp_pkg::OUT_COORD_W-1:0]      out_row,
  output logic [aesp_pkg::OUT_COORD_W-1:0]      out_column,
  output logic [aesp_pkg::BYTE_W-1:0]           out_glyph,
  output logic [aesp_pkg::COLOR_W-1:0]          out_foreground,
  output logic [aesp_pkg::COLOR_W-1:0]          out_background,
  output logic                                  out_bold,
  output logic                                  out_underline,
  output logic                                  out_blink,
  output logic                                  out_reverse,

  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [aesp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aesp_pkg::LW_W-1:0]             cfg_data
);

  aesp_pkg::dp_cmd_t    cmd;
  aesp_pkg::dp_status_t st;

  assign cfg_ready = 1'b1;

  aesp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  aesp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_byte        (in_input_byte),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_kind       (out_kind),
    .out_row        (out_row),
    .out_column     (out_column),
    .out_glyph      (out_glyph),
    .out_foreground (out_foreground),
    .out_background (out_background),
    .out_bold       (out_bold),
    .out_underline  (out_underline),
    .out_blink      (out_blink),
    .out_reverse    (out_reverse)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Byte-stream test of the escape sequence screen parser. A model in the
// bench tracks cursor, colors, attributes and partial sequences, and
// predicts every screen write. Each write the block delivers is compared
// field by field against the oldest prediction. Directed cases come first,
// then random streams of well-formed and broken sequences, run under
// several register settings with random gaps on both channels.
// ---------------------------------------------------------------------------
module tb_top;
  import aesp_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int MAX_GAP     = 17;
  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD   = 80;
  localparam int PRINT_LIMIT = 50;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int RANDOM_PHASES    = 8;
  localparam int BYTES_PER_PHASE  = 140;

  localparam logic [BYTE_W-1:0] CH_SEMI     = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;

  typedef struct {
    kind_t                  kind;
    logic [OUT_COORD_W-1:0] row;
    logic [OUT_COORD_W-1:0] column;
    logic [BYTE_W-1:0]      glyph;
    logic [COLOR_W-1:0]     fg;
    logic [COLOR_W-1:0]     bg;
    logic [ATTR_W-1:0]      attr;
  } screen_write_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [BYTE_W-1:0]      in_input_byte = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             out_kind;
  logic [OUT_COORD_W-1:0] out_row;
  logic [OUT_COORD_W-1:0] out_column;
  logic [BYTE_W-1:0]      out_glyph;
  logic [COLOR_W-1:0]     out_foreground;
  logic [COLOR_W-1:0]     out_background;
  logic                   out_bold;
  logic                   out_underline;
  logic                   out_blink;
  logic                   out_reverse;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [LW_W-1:0]        cfg_data = '0;

  ansi_escape_screen_parser dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_input_byte  (in_input_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_row        (out_row),
    .out_column     (out_column),
    .out_glyph      (out_glyph),
    .out_foreground (out_foreground),
    .out_background (out_background),
    .out_bold       (out_bold),
    .out_underline  (out_underline),
    .out_blink      (out_blink),
    .out_reverse    (out_reverse),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // bench-side copy of the parser state
  logic [COLOR_W-1:0] start_fg = RST_FG;
  logic [COLOR_W-1:0] start_bg = RST_BG;
  logic [ATTR_W-1:0]  start_attr = RST_ATTR;
  logic [LW_W-1:0]    line_width = RST_LW;
  logic [COLOR_W-1:0] cur_fg = RST_FG;
  logic [COLOR_W-1:0] cur_bg = RST_BG;
  logic [ATTR_W-1:0]  cur_attr = RST_ATTR;
  bit                 in_csi = 1'b0;
  int                 csi_len = 0;
  int                 num_acc = 0;
  int                 num_digits = 0;
  int                 param_cnt = 0;
  int                 param_val [MAX_PARAMS];
  bit                 param_ok [MAX_PARAMS];
  int                 cur_row = 0;
  int                 cur_col = 0;
  int                 saved_row = 0;
  int                 saved_col = 0;

  screen_write_t pending_writes[$];

  int  error_count = 0;
  int  bytes_sent = 0;
  int  quiet_cycles = 0;
  int  hold_cycles = 0;
  bit  send_gap_on = 1'b1;
  bit  sink_gap_on = 1'b1;

  initial begin
    foreach (param_ok[i]) begin
      param_ok[i] = 1'b0;
      param_val[i] = 0;
    end
  end

  // ---------------- prediction ----------------

  function automatic int sat_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  task automatic push_write(kind_t k, int r, int c, logic [BYTE_W-1:0] g,
                            logic [COLOR_W-1:0] f, logic [COLOR_W-1:0] b,
                            logic [ATTR_W-1:0] a);
    screen_write_t w;
    w.kind   = k;
    w.row    = OUT_COORD_W'(r);
    w.column = OUT_COORD_W'(c);
    w.glyph  = g;
    w.fg     = f;
    w.bg     = b;
    w.attr   = a;
    pending_writes.push_back(w);
  endtask

  task automatic commit_param();
    if (num_digits > 0 && param_cnt < MAX_PARAMS) begin
      param_val[param_cnt] = num_acc;
      param_ok[param_cnt] = 1'b1;
      param_cnt++;
    end
    num_acc = 0;
    num_digits = 0;
  endtask

  task automatic run_final(logic [BYTE_W-1:0] letter);
    int p0;
    int v;
    p0 = param_ok[0] ? param_val[0] : 0;
    case (letter)
      CH_SGR: begin
        for (int i = 0; i < MAX_PARAMS; i++) begin
          if (param_ok[i]) begin
            v = param_val[i];
            if (v == int'(SGR_RESET)) cur_attr = '0;
            else if (v == int'(SGR_BOLD)) cur_attr[0] = 1'b1;
            else if (v == int'(SGR_UNDERLINE)) cur_attr[1] = 1'b1;
            else if (v == int'(SGR_BLINK)) cur_attr[2] = 1'b1;
            else if (v == int'(SGR_REVERSE)) cur_attr[3] = 1'b1;
            else if (v >= int'(SGR_FG_LO) && v <= int'(SGR_FG_HI))
              cur_fg = COLOR_W'(v - int'(SGR_FG_LO));
            else if (v >= int'(SGR_BG_LO) && v <= int'(SGR_BG_HI))
              cur_bg = COLOR_W'(v - int'(SGR_BG_LO));
          end
        end
      end
      CH_CUP, CH_HVP: begin
        if (param_ok[0]) cur_row = sat_coord(p0);
        if (param_ok[1]) cur_col = sat_coord(param_val[1]);
      end
      CH_CUU: if (param_ok[0]) cur_row = sat_coord(cur_row - p0);
      CH_CUD: if (param_ok[0]) cur_row = sat_coord(cur_row + p0);
      CH_CUF: if (param_ok[0]) cur_col = sat_coord(cur_col + p0);
      CH_CUB: if (param_ok[0]) cur_col = sat_coord(cur_col - p0);
      CH_SCP: begin
        saved_row = cur_row;
        saved_col = cur_col;
      end
      CH_RCP: begin
        cur_row = saved_row;
        cur_col = saved_col;
      end
      CH_ED: begin
        if (param_ok[0] && p0 == int'(ED_ALL)) begin
          cur_row = 0;
          cur_col = 0;
          push_write(KIND_CLEAR, 0, 0, CH_SPACE, cur_fg, cur_bg, cur_attr);
        end
      end
      CH_EL: begin
        // erase uses the start colors, not the current ones
        if (cur_col < int'(line_width))
          push_write(KIND_ERASE, cur_row, cur_col, CH_SPACE, start_fg, start_bg,
                     start_attr);
      end
      default: ;
    endcase
  endtask

  task automatic model_byte(logic [BYTE_W-1:0] b);
    bit is_letter;
    is_letter = (b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z);
    if (b == CH_LF) begin
      in_csi = 1'b0;
      cur_row = sat_coord(cur_row + 1);
      cur_col = 0;
    end else if (in_csi) begin
      if (csi_len >= MAX_SEQUENCE) begin
        in_csi = 1'b0;
      end else begin
        csi_len++;
        if (b >= CH_ZERO && b <= CH_NINE) begin
          if (num_digits < MAX_DIGITS) begin
            num_acc = num_acc * 10 + int'(b - CH_ZERO);
            if (num_acc > ACC_MAX) num_acc = ACC_MAX;
            num_digits++;
          end
        end else begin
          commit_param();
          if (is_letter) begin
            in_csi = 1'b0;
            run_final(b);
          end
        end
      end
    end else if (b == CH_ESC) begin
      in_csi = 1'b1;
      csi_len = 0;
      num_acc = 0;
      num_digits = 0;
      param_cnt = 0;
      foreach (param_ok[i]) param_ok[i] = 1'b0;
    end else begin
      push_write(KIND_CHAR, cur_row, cur_col, b, cur_fg, cur_bg, cur_attr);
      cur_col = sat_coord(cur_col + 1);
    end
  endtask

  task automatic apply_reg(cfg_reg_t idx, logic [LW_W-1:0] value);
    case (idx)
      REG_START_FG: begin
        start_fg = COLOR_W'(value);
        cur_fg = start_fg;
      end
      REG_START_BG: begin
        start_bg = COLOR_W'(value);
        cur_bg = start_bg;
      end
      REG_START_ATTR: begin
        start_attr = ATTR_W'(value);
        cur_attr = start_attr;
      end
      REG_LINE_WIDTH: line_width = value;
      default: ;
    endcase
  endtask

  // ---------------- checking ----------------

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < PRINT_LIMIT)
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch(name, got, want);
  endtask

  always @(posedge clk) begin
    screen_write_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("write with nothing pending, glyph", int'(out_glyph), -1);
      end else begin
        w = pending_writes.pop_front();
        check_field("kind", int'(out_kind), int'(w.kind));
        check_field("row", int'(out_row), int'(w.row));
        check_field("column", int'(out_column), int'(w.column));
        check_field("glyph", int'(out_glyph), int'(w.glyph));
        check_field("foreground", int'(out_foreground), int'(w.fg));
        check_field("background", int'(out_background), int'(w.bg));
        check_field("bold", int'(out_bold), int'(w.attr[0]));
        check_field("underline", int'(out_underline), int'(w.attr[1]));
        check_field("blink", int'(out_blink), int'(w.attr[2]));
        check_field("reverse", int'(out_reverse), int'(w.attr[3]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result sink: random stalls per item, plus an occasional long hold
  initial begin : result_sink
    int gap;
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      gap = sink_gap_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic send_byte(logic [BYTE_W-1:0] b);
    int gap;
    gap = send_gap_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_input_byte <= b;
    do @(posedge clk); while (!in_ready);
    model_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_csi(string params, logic [BYTE_W-1:0] letter);
    send_byte(CH_ESC);
    send_byte(CH_LBRACKET);
    send_str(params);
    send_byte(letter);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [LW_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // all results in, then a further wait for a byte that made no result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic int pick_param();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return int'(SGR_RESET);
          1: return int'(SGR_BOLD);
          2: return int'(SGR_UNDERLINE);
          3: return int'(SGR_BLINK);
          default: return int'(SGR_REVERSE);
        endcase
      end
      1: return int'(SGR_FG_LO) + $urandom_range(0, 7);
      2: return int'(SGR_BG_LO) + $urandom_range(0, 7);
      3: return int'(ED_ALL);
      4: return $urandom_range(0, 99);
      5: return $urandom_range(0, 1100);
      6: return $urandom_range(9990, 99999);
      default: return $urandom_range(0, 9);
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_final();
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 0) return CH_UP_A + BYTE_W'($urandom_range(0, 25));
      return CH_LO_A + BYTE_W'($urandom_range(0, 25));
    end
    case ($urandom_range(0, 10))
      0: return CH_SGR;
      1: return CH_CUP;
      2: return CH_HVP;
      3: return CH_CUU;
      4: return CH_CUD;
      5: return CH_CUF;
      6: return CH_CUB;
      7: return CH_SCP;
      8: return CH_RCP;
      9: return CH_ED;
      default: return CH_EL;
    endcase
  endfunction

  // mostly well-formed sequences; some are cut by LF, overlong, carry a
  // second ESC (which only closes the pending number) or stray bytes
  task automatic send_random_csi();
    logic [BYTE_W-1:0] seq_q[$];
    int    nparams;
    int    style;
    string digits;
    seq_q.push_back(CH_ESC);
    if ($urandom_range(0, 3) != 0) seq_q.push_back(CH_LBRACKET);
    nparams = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
    for (int i = 0; i < nparams; i++) begin
      digits = $sformatf("%0d", pick_param());
      if ($urandom_range(0, 9) == 0) digits = {"0", digits};
      for (int j = 0; j < digits.len(); j++) seq_q.push_back(digits[j]);
      if (i < nparams - 1) begin
        if ($urandom_range(0, 9) == 0) seq_q.push_back(BYTE_W'($urandom_range(0, 255)));
        else seq_q.push_back(CH_SEMI);
      end
    end
    style = $urandom_range(0, 19);
    case (style)
      0: seq_q.push_back(CH_LF);
      1: repeat (MAX_SEQUENCE + 2) seq_q.push_back(CH_ZERO + BYTE_W'($urandom_range(0, 9)));
      2: seq_q.push_back(CH_ESC);
      3: seq_q.push_back(BYTE_W'($urandom_range(0, 255)));
      default: ;
    endcase
    if (style != 0) seq_q.push_back(pick_final());
    foreach (seq_q[k]) send_byte(seq_q[k]);
  endtask

  task automatic send_random_text();
    int n;
    n = $urandom_range(1, 16);
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) send_byte(CH_LF);
      else send_byte(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic randomize_config();
    logic [LW_W-1:0] lw;
    case ($urandom_range(0, 4))
      0: lw = 11'd1;
      1: lw = 11'd1024;
      2: lw = RST_LW;
      default: lw = LW_W'($urandom_range(1, 1024));
    endcase
    write_reg(REG_START_FG, LW_W'($urandom_range(0, 7)));
    write_reg(REG_START_BG, LW_W'($urandom_range(0, 7)));
    write_reg(REG_START_ATTR, LW_W'($urandom_range(0, 15)));
    write_reg(REG_LINE_WIDTH, lw);
  endtask

  // ---------------- tests ----------------

  task automatic test_reset_values();
    send_byte(8'h41);
    send_byte(8'h42);
    send_csi("", CH_EL);
  endtask

  task automatic test_text_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_LF);
    send_byte(8'h7F);
    send_byte(CH_SPACE);
  endtask

  task automatic test_sgr();
    send_csi("1;4;5;7;31", CH_SGR);
    send_byte(8'h61);
    // sixth code is dropped, so underline stays off after the reset
    send_csi("0;1;2;3;7;4", CH_SGR);
    send_byte(8'h62);
    send_csi("0;37;47;38;99", CH_SGR);
    send_byte(8'h63);
  endtask

  task automatic test_cursor_moves();
    send_csi("5;9", CH_CUP);
    send_byte(8'h2A);
    send_csi("9999;9999", CH_HVP);
    send_byte(8'h2B);
    send_byte(8'h2C);
    send_byte(CH_LF);
    send_byte(8'h2D);
    send_csi("3", CH_CUU);
    send_csi("4", CH_CUD);
    send_csi("2", CH_CUF);
    send_csi("7", CH_CUB);
    send_csi("", CH_CUU);
    send_byte(8'h2E);
    send_csi("9999", CH_CUB);
    send_csi("9999", CH_CUU);
    send_byte(8'h2F);
    send_csi("12;34", CH_CUP);
    send_csi("", CH_SCP);
    send_csi("1;1", CH_HVP);
    send_csi("", CH_RCP);
    send_byte(8'h3F);
  endtask

  task automatic test_erase();
    send_csi("2", CH_ED);
    send_csi("1", CH_ED);
    send_csi("", CH_ED);
    send_csi("", CH_EL);
    send_csi("0;79", CH_CUP);
    send_csi("", CH_EL);
    send_csi("0;80", CH_CUP);
    send_csi("", CH_EL);
  endtask

  task automatic test_malformed();
    // overlong: the byte past the limit is dropped, the rest is text
    send_byte(CH_ESC);
    send_str("1234567890123456x");
    // line feed cuts the sequence and still moves down
    send_byte(CH_ESC);
    send_str("[12");
    send_byte(CH_LF);
    send_byte(8'h78);
    // a second escape inside a sequence only closes the pending number
    send_byte(CH_ESC);
    send_str("[3");
    send_byte(CH_ESC);
    send_csi("5", CH_CUF);
    // only four digits are kept
    send_csi("123456", CH_CUF);
    send_csi("7", CH_UP_Z);
    send_byte(8'h79);
  endtask

  task automatic test_config_extremes();
    wait_idle();
    write_reg(REG_START_FG, 11'd0);
    write_reg(REG_START_BG, 11'd7);
    write_reg(REG_START_ATTR, 11'd15);
    write_reg(REG_LINE_WIDTH, 11'd1);
    send_byte(8'h51);
    send_csi("", CH_EL);
    send_csi("0;0", CH_CUP);
    send_csi("", CH_EL);
    send_csi("0;32", CH_SGR);
    send_csi("2", CH_ED);
    wait_idle();
    write_reg(REG_START_FG, 11'd7);
    write_reg(REG_START_BG, 11'd0);
    write_reg(REG_START_ATTR, 11'd0);
    write_reg(REG_LINE_WIDTH, 11'd1024);
    send_csi("0;1023", CH_CUP);
    send_csi("", CH_EL);
    send_byte(8'h52);
    send_csi("", CH_EL);
    wait_idle();
    write_reg(REG_LINE_WIDTH, RST_LW);
  endtask

  task automatic test_backpressure();
    wait_idle();
    send_gap_on = 1'b0;
    hold_cycles = LONG_HOLD;
    repeat (24) send_byte(BYTE_W'($urandom_range(33, 126)));
    send_gap_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_stream();
    int target;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      randomize_config();
      send_gap_on = (phase != 2) && (phase != 6);
      sink_gap_on = (phase != 4) && (phase != 6);
      target = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < target) begin
        if ($urandom_range(0, 9) < 6) send_random_csi();
        else send_random_text();
      end
    end
    send_gap_on = 1'b1;
    sink_gap_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_values();
    test_text_bytes();
    test_sgr();
    test_cursor_moves();
    test_erase();
    test_malformed();
    test_config_extremes();
    test_backpressure();
    test_random_stream();
    wait_idle();
    repeat (8) @(negedge clk);
    if (pending_writes.size() != 0)
      report_mismatch("writes never delivered", 0, pending_writes.size());
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
